/* src/ksh_pkg.sv */
// Package: lane type, SipHash constants and round functions for the keyed SipHash-2-4 core.
package ksh_pkg;

    localparam int WORD_W  = 64;
    localparam int CNT_W   = 4;
    localparam int LEN_W   = 8;
    localparam int TDATA_W = 72;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

    localparam logic [CNT_W-1:0] FULL_COUNT = 4'd8;
    localparam logic [LEN_W-1:0] FULL_BYTES = 8'd8;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } lanes_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
        rotl = (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic lanes_t sip_round(input lanes_t l);
        lanes_t r;
        r = l;
        r.a = r.a + r.b; r.b = rotl(r.b, 13); r.b = r.b ^ r.a; r.a = rotl(r.a, 32);
        r.c = r.c + r.d; r.d = rotl(r.d, 16); r.d = r.d ^ r.c;
        r.a = r.a + r.d; r.d = rotl(r.d, 21); r.d = r.d ^ r.a;
        r.c = r.c + r.b; r.b = rotl(r.b, 17); r.b = r.b ^ r.c; r.c = rotl(r.c, 32);
        return r;
    endfunction

    function automatic lanes_t sip_double(input lanes_t l);
        return sip_round(sip_round(l));
    endfunction

    function automatic lanes_t sip_absorb(input lanes_t l, input logic [WORD_W-1:0] m);
        lanes_t r;
        r = l;
        r.d = r.d ^ m;
        r = sip_double(r);
        r.a = r.a ^ m;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] sip_fold(input lanes_t l);
        return l.a ^ l.b ^ l.c ^ l.d;
    endfunction

endpackage

/* src/keyed_siphash_2_4_core.sv */
// Top level: key registers, input word register and the SipHash-2-4 pipeline.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tdata: message_word, byte_count; s_tlast
//  m_       | out       | m_tvalid / m_tready  | m_tdata: hash_value
//  cfg_     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One word is taken every cycle while s_tready is high; two SipRounds in the compression
//  stage close the lane loop. After acceptance a last word's hash passes through the input register,
//  compression, tail absorb, two finishing stages of two rounds each into the result register.
//  Reset clears the key, the open-message flag and all pipeline valids.
//  A stalled m_tready fills the pipeline stage by stage before s_tready falls.
module keyed_siphash_2_4_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ksh_pkg::TDATA_W-1:0]       s_tdata,   // message_word [63:0], byte_count [67:64], zero [71:68]
    input  logic                              s_tlast,   // is_last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ksh_pkg::WORD_W-1:0]        m_tdata,   // hash_value [63:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ksh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ksh_pkg::WORD_W-1:0]        cfg_data
);
    import ksh_pkg::*;

    logic [WORD_W-1:0]  key_low_reg;
    logic [WORD_W-1:0]  key_high_reg;
    logic               in_valid_reg;
    logic [WORD_W-1:0]  in_word_reg;
    logic [CNT_W-1:0]   in_cnt_reg;
    logic               in_last_reg;

    logic               core_ready;
    logic               fin_valid;
    logic               fin_ready;
    lanes_t             fin_lanes;
    logic [WORD_W-1:0]  fin_tail;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= s_tdata[WORD_W-1:0];
            in_cnt_reg  <= s_tdata[WORD_W +: CNT_W];
            in_last_reg <= s_tlast;
        end
    end

    ksh_compress u_compress
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_low   (key_low_reg),
        .key_high  (key_high_reg),
        .in_valid  (in_valid_reg),
        .in_ready  (core_ready),
        .in_word   (in_word_reg),
        .in_cnt    (in_cnt_reg),
        .in_last   (in_last_reg),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_lanes (fin_lanes),
        .fin_tail  (fin_tail)
    );

    ksh_final u_final
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_lanes (fin_lanes),
        .fin_tail  (fin_tail),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hash      (m_tdata)
    );

endmodule

/* src/ksh_compress.sv */
// Compression stage: holds the running lanes and forms the tail block on the last word.
module ksh_compress
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ksh_pkg::WORD_W-1:0]   key_low,
    input  logic [ksh_pkg::WORD_W-1:0]   key_high,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ksh_pkg::WORD_W-1:0]   in_word,
    input  logic [ksh_pkg::CNT_W-1:0]    in_cnt,
    input  logic                         in_last,
    output logic                         fin_valid,
    input  logic                         fin_ready,
    output ksh_pkg::lanes_t              fin_lanes,
    output logic [ksh_pkg::WORD_W-1:0]   fin_tail
);
    import ksh_pkg::*;

    lanes_t             lanes_reg;
    logic [LEN_W-1:0]   total_reg;
    logic               open_reg;
    logic               open_next;
    logic               fin_valid_reg;
    logic               fin_valid_next;
    lanes_t             fin_lanes_reg;
    logic [WORD_W-1:0]  fin_tail_reg;

    lanes_t             init_lanes;
    lanes_t             cur_lanes;
    lanes_t             absorbed;
    logic [LEN_W-1:0]   cur_total;
    logic [LEN_W-1:0]   total_new;
    logic               full_word;
    logic [CNT_W-1:0]   eff_cnt;
    logic [WORD_W-1:0]  tail;
    logic               take;

    always_comb
    begin
        init_lanes.a = SIP_C0 ^ key_low;
        init_lanes.b = SIP_C1 ^ key_high;
        init_lanes.c = SIP_C2 ^ key_low;
        init_lanes.d = SIP_C3 ^ key_high;
        cur_lanes    = open_reg ? lanes_reg : init_lanes;
        cur_total    = open_reg ? total_reg : '0;
        absorbed     = sip_absorb(cur_lanes, in_word);
        full_word    = in_cnt[CNT_W-1];
        eff_cnt      = full_word ? FULL_COUNT : in_cnt;
        total_new    = cur_total + LEN_W'(eff_cnt);
        tail         = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (!full_word && (CNT_W'(i) < eff_cnt))
            begin
                tail[8*i +: 8] = in_word[8*i +: 8];
            end
        end
        tail[WORD_W-1 -: LEN_W] = total_new;
    end

    assign in_ready = !fin_valid_reg || fin_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        open_next      = open_reg;
        fin_valid_next = fin_valid_reg && !fin_ready;
        if (take)
        begin
            open_next = !in_last;
            if (in_last)
            begin
                fin_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (!in_last)
            begin
                lanes_reg <= absorbed;
                total_reg <= cur_total + FULL_BYTES;
            end
            else
            begin
                fin_lanes_reg <= full_word ? absorbed : cur_lanes;
                fin_tail_reg  <= tail;
            end
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_lanes = fin_lanes_reg;
    assign fin_tail  = fin_tail_reg;

endmodule

/* src/ksh_final.sv */
// Finalisation pipeline: tail absorb, four finishing rounds and the hash result register.
module ksh_final
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fin_valid,
    output logic                         fin_ready,
    input  ksh_pkg::lanes_t              fin_lanes,
    input  logic [ksh_pkg::WORD_W-1:0]   fin_tail,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ksh_pkg::WORD_W-1:0]   hash
);
    import ksh_pkg::*;

    logic               s1_valid_reg;
    lanes_t             s1_lanes_reg;
    logic               s2_valid_reg;
    lanes_t             s2_lanes_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  hash_reg;

    logic               out_adv;
    logic               s1_adv;
    lanes_t             s1_marked;

    assign out_adv   = !out_valid_reg || out_ready;
    assign s1_adv    = !s2_valid_reg || out_adv;
    assign fin_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_marked   = s1_lanes_reg;
        s1_marked.c = s1_lanes_reg.c ^ FINAL_MARK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_ready)
            begin
                s1_valid_reg <= fin_valid;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && fin_valid)
        begin
            s1_lanes_reg <= sip_absorb(fin_lanes, fin_tail);
        end
        if (s1_adv && s1_valid_reg)
        begin
            s2_lanes_reg <= sip_double(s1_marked);
        end
        if (out_adv && s2_valid_reg)
        begin
            hash_reg <= sip_fold(sip_double(s2_lanes_reg));
        end
    end

    assign out_valid = out_valid_reg;
    assign hash      = hash_reg;

endmodule
